@@ hdl/kscl_pkg.sv @@
// kscl_pkg: shared types, constants and key decode for the keypad code lock
// no dependencies; imported by the top level, front, back and the bench

package kscl_pkg;

	// default sizes, handed down from the top level
	localparam int CODE_LENGTH_DEF = 11;
	localparam int KEY_ROWS_DEF    = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	// digits held by the secret code register
	localparam int SECRET_DIGITS = 11;

	// register widths and reset values
	localparam int SCAN_W   = 16;
	localparam int SECRET_W = 4 * SECRET_DIGITS;
	localparam logic [SCAN_W-1:0]   SCAN_INTERVAL_RST = 16'd25;
	localparam logic [SECRET_W-1:0] SECRET_CODE_RST   = 44'h920_0050_4326;

	// register indexes on the configuration port
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCAN_INTERVAL = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SECRET_CODE   = 1'b1;

	// function key codes on the key map
	localparam int MAP_W = 16;
	localparam logic [MAP_W-1:0] KEY_CLEAR = 16'h0008;
	localparam logic [MAP_W-1:0] KEY_BACK  = 16'h0080;
	localparam logic [MAP_W-1:0] KEY_ENTER = 16'h8000;

	// scanned item passed from front to back
	typedef struct packed {
		logic [3:0]       row_lines;
		logic [MAP_W-1:0] key_map;
		logic [MAP_W-1:0] code;
	} scan_t;

	// one result item
	typedef struct packed {
		logic [3:0]       row_drive;
		logic             led_on;
		logic             unlocked;
		logic [3:0]       digits_entered;
		logic [MAP_W-1:0] key_map;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} digit_t;

	// single-key code to digit
	function automatic digit_t key_digit(input logic [MAP_W-1:0] code);
		digit_t d;
		d.valid = 1'b1;
		unique case (code)
			16'h0001: d.value = 4'd7;
			16'h0002: d.value = 4'd8;
			16'h0004: d.value = 4'd9;
			16'h0010: d.value = 4'd4;
			16'h0020: d.value = 4'd5;
			16'h0040: d.value = 4'd6;
			16'h0100: d.value = 4'd1;
			16'h0200: d.value = 4'd2;
			16'h0400: d.value = 4'd3;
			16'h1000: d.value = 4'd0;
			default: begin
				d.valid = 1'b0;
				d.value = 4'd0;
			end
		endcase
		return d;
	endfunction

endpackage

@@ hdl/keypad_scanner_code_lock.sv @@
// keypad_scanner_code_lock: keypad row scanner with digit code lock, top level
// path: a tick is stored in the middle queue, then decoded into the result queue
// throughput: one tick per cycle; front scanner, queue, lock logic and result queue
// each take one item per cycle, so a full result queue is the only stall source
// reset: arst_n clears scan state, entry buffer, lamp and queues and presets the registers at once
// depends on kscl_pkg, kscl_fifo, kscl_front, kscl_back

module keypad_scanner_code_lock
	import kscl_pkg::*;
#(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF,
	parameter int KEY_ROWS    = KEY_ROWS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [SECRET_W-1:0]    cfg_data,
	input  logic                   push,
	output logic                   full,
	input  logic [3:0]             column_levels,
	output logic                   empty,
	input  logic                   pop,
	output logic [3:0]             row_drive,
	output logic                   led_on,
	output logic                   unlocked,
	output logic [3:0]             digits_entered,
	output logic [MAP_W-1:0]       key_map
);

	logic [SCAN_W-1:0]   scan_interval_q;
	logic [SECRET_W-1:0] secret_code_q;

	logic    mid_push;
	logic    mid_full;
	logic    mid_pop;
	logic    mid_empty;
	scan_t   mid_in;
	scan_t   mid_out;
	logic    res_push;
	logic    res_full;
	result_t res_in;
	result_t res_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_interval_q <= SCAN_INTERVAL_RST;
			secret_code_q   <= SECRET_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCAN_INTERVAL: scan_interval_q <= cfg_data[SCAN_W-1:0];
				REG_SECRET_CODE:   secret_code_q   <= cfg_data;
				default:           secret_code_q   <= secret_code_q;
			endcase
		end
	end

	// front: tick counting and row scan
	kscl_front #(
		.KEY_ROWS(KEY_ROWS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.column_levels(column_levels),
		.scan_interval(scan_interval_q),
		.q_full       (mid_full),
		.q_push       (mid_push),
		.q_data       (mid_in)
	);

	assign full = mid_full;

	// queue between front and back
	kscl_fifo #(
		.WIDTH($bits(scan_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (mid_push),
		.push_data(mid_in),
		.full     (mid_full),
		.pop      (mid_pop),
		.pop_data (mid_out),
		.empty    (mid_empty)
	);

	// back: decode and code lock
	kscl_back #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (mid_empty),
		.q_data     (mid_out),
		.q_pop      (mid_pop),
		.secret_code(secret_code_q),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	// result queue
	kscl_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res_in),
		.full     (res_full),
		.pop      (pop),
		.pop_data (res_out),
		.empty    (empty)
	);

	assign row_drive      = res_out.row_drive;
	assign led_on         = res_out.led_on;
	assign unlocked       = res_out.unlocked;
	assign digits_entered = res_out.digits_entered;
	assign key_map        = res_out.key_map;

`ifndef SYNTH
	// a match empties the entry buffer
	a_unlock_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && unlocked) |-> (digits_entered == 4'd0))
		else $error("unlock result with digits still entered");

	// a match always lights the lamp
	a_unlock_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && unlocked) |-> led_on)
		else $error("unlock result with lamp dark");

	// row drive is idle or a single low line
	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ($onehot(~row_drive) || row_drive == 4'hF))
		else $error("row drive has several active lines");

	// back never moves an item into a full result queue
	a_back_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!res_full && !mid_empty))
		else $error("back transfer without room or data");
`endif

endmodule

@@ hdl/kscl_fifo.sv @@
// kscl_fifo: small synchronous queue with push/full and pop/empty sides
// no dependencies; used between front and back and on the result side

module kscl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = slots_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/kscl_front.sv @@
// kscl_front: tick counter and row scanner; classifies each tick into a scan item
// depends on kscl_pkg

module kscl_front
	import kscl_pkg::*;
#(
	parameter int KEY_ROWS = KEY_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [3:0]        column_levels,
	input  logic [SCAN_W-1:0] scan_interval,
	input  logic              q_full,
	output logic              q_push,
	output scan_t             q_data
);

	localparam int ROW_W = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;

	logic [SCAN_W-1:0] ticks_q;
	logic [ROW_W-1:0]  row_q;
	logic [3:0]        row_lines_q;
	logic [MAP_W-1:0]  map_q;

	logic [SCAN_W-1:0] ticks_inc;
	logic              scan;
	logic              any_press;
	logic [ROW_W-1:0]  row_inc;
	logic [MAP_W-1:0]  map_scan;
	logic [3:0]        lines_scan;
	logic              accept;

	assign accept    = push & ~q_full;
	assign q_push    = accept;
	assign ticks_inc = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;
	assign scan      = (ticks_inc >= scan_interval);
	assign any_press = (column_levels != 4'hF);
	assign row_inc   = (row_q == ROW_W'(KEY_ROWS - 1)) ? '0 : row_q + 1'b1;

	// sample the driven row and select the next row line
	always_comb begin
		map_scan = map_q;
		for (int r = 0; r < 4; r++) begin
			if (int'(row_q) == r) begin
				map_scan[4*r +: 4] = ~column_levels;
			end
			lines_scan[r] = (int'(row_inc) != r);
		end
	end

	// item for the back part
	always_comb begin
		q_data.row_lines = scan ? lines_scan : row_lines_q;
		q_data.key_map   = scan ? map_scan : map_q;
		q_data.code      = (scan && any_press) ? map_scan : '0;
	end

	// scan state, advanced on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q     <= '0;
			row_q       <= '0;
			row_lines_q <= 4'hF;
			map_q       <= '0;
		end else if (accept) begin
			if (scan) begin
				ticks_q     <= '0;
				row_q       <= row_inc;
				row_lines_q <= lines_scan;
				map_q       <= map_scan;
			end else begin
				ticks_q <= ticks_inc;
			end
		end
	end

endmodule

@@ hdl/kscl_back.sv @@
// kscl_back: key decode, entry buffer, code compare and lamp control
// depends on kscl_pkg

module kscl_back
	import kscl_pkg::*;
#(
	parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  scan_t               q_data,
	output logic                q_pop,
	input  logic [SECRET_W-1:0] secret_code,
	input  logic                res_full,
	output logic                res_push,
	output result_t             res_data
);

	localparam int CNT_W = $clog2(CODE_LENGTH + 1);
	localparam int EXT_W = 4 * ((CODE_LENGTH > SECRET_DIGITS) ? CODE_LENGTH : SECRET_DIGITS);

	logic [3:0]       digits_q [CODE_LENGTH];
	logic [CNT_W-1:0] cnt_q;
	logic             await_q;
	logic             lamp_q;

	logic [3:0]       digits_d [CODE_LENGTH];
	logic [CNT_W-1:0] cnt_d;
	logic             await_d;
	logic             lamp_d;
	logic             match;
	logic             code_ok;
	logic [EXT_W-1:0] secret_ext;
	digit_t           dig;

	assign q_pop      = ~q_empty & ~res_full;
	assign res_push   = q_pop;
	assign secret_ext = EXT_W'(secret_code);
	assign dig        = key_digit(q_data.code);

	// compare every slot with the secret code
	always_comb begin
		code_ok = 1'b1;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (digits_q[i] != secret_ext[4*i +: 4]) begin
				code_ok = 1'b0;
			end
		end
	end

	// key action
	always_comb begin
		digits_d = digits_q;
		cnt_d    = cnt_q;
		await_d  = await_q;
		lamp_d   = lamp_q;
		match    = 1'b0;
		priority if (dig.valid && !await_q) begin
			if (cnt_q < CNT_W'(CODE_LENGTH)) begin
				for (int i = 0; i < CODE_LENGTH; i++) begin
					if (cnt_q == CNT_W'(i)) begin
						digits_d[i] = dig.value;
					end
				end
				cnt_d = cnt_q + 1'b1;
			end
			await_d = 1'b1;
		end else if (q_data.code == KEY_CLEAR) begin
			for (int i = 0; i < CODE_LENGTH; i++) begin
				digits_d[i] = '0;
			end
			cnt_d   = '0;
			lamp_d  = 1'b1;
			await_d = 1'b1;
		end else if (q_data.code == KEY_ENTER && !await_q) begin
			match = code_ok;
			for (int i = 0; i < CODE_LENGTH; i++) begin
				digits_d[i] = '0;
			end
			cnt_d   = '0;
			lamp_d  = 1'b1;
			await_d = 1'b1;
		end else if (await_q && q_data.key_map == '0) begin
			await_d = 1'b0;
			lamp_d  = 1'b0;
		end else if (q_data.code == KEY_BACK && !await_q) begin
			if (cnt_q != '0) begin
				for (int i = 0; i < CODE_LENGTH; i++) begin
					if (cnt_q == CNT_W'(i + 1)) begin
						digits_d[i] = '0;
					end
				end
				cnt_d = cnt_q - 1'b1;
			end
			await_d = 1'b1;
		end else if (await_q && q_data.key_map != '0) begin
			lamp_d = 1'b1;
		end else begin
			lamp_d = lamp_q;
		end
	end

	// result item
	always_comb begin
		res_data.row_drive      = q_data.row_lines;
		res_data.led_on         = lamp_d;
		res_data.unlocked       = match;
		res_data.digits_entered = 4'(cnt_d);
		res_data.key_map        = q_data.key_map;
	end

	// lock state, updated on each transfer from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CODE_LENGTH; i++) begin
				digits_q[i] <= '0;
			end
			cnt_q   <= '0;
			await_q <= 1'b0;
			lamp_q  <= 1'b0;
		end else if (q_pop) begin
			digits_q <= digits_d;
			cnt_q    <= cnt_d;
			await_q  <= await_d;
			lamp_q   <= lamp_d;
		end
	end

endmodule

@@ dv/keypad_scanner_code_lock_test.sv @@
// keypad_scanner_code_lock_test: self-checking bench for the keypad scanner code lock
// drives column-level ticks as queue transfers, predicts every result in-bench
// depends on kscl_pkg and keypad_scanner_code_lock
`timescale 1ns / 100ps

module keypad_scanner_code_lock_test;
	import kscl_pkg::*;

	localparam int CODE_LEN    = CODE_LENGTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 60;

	// key positions on the map, bit = column + 4 * row
	localparam int POS_CLEAR  = $clog2(KEY_CLEAR);
	localparam int POS_BACK   = $clog2(KEY_BACK);
	localparam int POS_ENTER  = $clog2(KEY_ENTER);
	localparam int POS_UNUSED = 11;
	localparam int DIGIT_POS [10] = '{12, 8, 9, 10, 4, 5, 6, 0, 1, 2};

	// idling per phase: none, sender idle, receiver stall, both
	localparam int SEND_IDLE [4]  = '{0, 77, 0, 17};
	localparam int RECV_STALL [4] = '{0, 0, 77, 17};
	localparam int PHASE_PERIOD [4] = '{1, 2, 1, 1};

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [SECRET_W-1:0]  cfg_data      = '0;
	logic                 push          = 1'b0;
	logic                 full;
	logic [3:0]           column_levels = 4'hF;
	logic                 empty;
	logic                 pop           = 1'b0;
	logic [3:0]           row_drive;
	logic                 led_on;
	logic                 unlocked;
	logic [3:0]           digits_entered;
	logic [MAP_W-1:0]     key_map;

	keypad_scanner_code_lock u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.column_levels (column_levels),
		.empty         (empty),
		.pop           (pop),
		.row_drive     (row_drive),
		.led_on        (led_on),
		.unlocked      (unlocked),
		.digits_entered(digits_entered),
		.key_map       (key_map)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// column ticks waiting to be sent, and lock outputs waiting to be seen
	logic [3:0] tick_queue [$];
	result_t    lock_results_due [$];

	int errors         = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_start     = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int idle_cycles    = 0;

	// predicted lock state and registers
	logic [15:0]      scan_period = SCAN_INTERVAL_RST;
	logic [SECRET_W-1:0] code_word = SECRET_CODE_RST;
	logic [15:0]      scan_count  = '0;
	logic [1:0]       row_idx     = '0;
	logic [3:0]       row_out     = 4'hF;
	logic [MAP_W-1:0] key_bits    = '0;
	logic [3:0]       entry_buf [CODE_LEN] = '{default: '0};
	logic [3:0]       entry_count = '0;
	logic             waiting     = 1'b0;
	logic             lamp        = 1'b0;

	// scan timing as the stimulus generator sees it
	int         g_ticks  = 0;
	int         g_period = int'(SCAN_INTERVAL_RST);
	logic [1:0] g_row    = '0;
	int         phase_items = 0;

	function automatic void clear_entry();
		foreach (entry_buf[i]) entry_buf[i] = '0;
		entry_count = '0;
	endfunction

	// one tick of the lock: scan, decode, buffer update
	function automatic result_t lock_tick(input logic [3:0] cols);
		result_t     r;
		logic [15:0] code;
		logic        pressed;
		logic        opened;
		int          dig;
		code    = '0;
		pressed = 1'b0;
		opened  = 1'b0;
		dig     = -1;
		if (scan_count != 16'hFFFF) scan_count = scan_count + 16'd1;
		if (scan_count >= scan_period) begin
			scan_count = '0;
			for (int c = 0; c < 4; c++) begin
				key_bits[{row_idx, 2'b00} + c] = ~cols[c];
				pressed |= ~cols[c];
			end
			row_idx = row_idx + 2'd1;
			row_out = ~(4'b0001 << row_idx);
			if (pressed) code = key_bits;
		end
		for (int k = 0; k < 10; k++) begin
			if (code == (16'b1 << DIGIT_POS[k])) dig = k;
		end
		if (dig >= 0 && !waiting) begin
			if (entry_count < CODE_LEN) begin
				entry_buf[entry_count] = dig[3:0];
				entry_count = entry_count + 4'd1;
			end
			waiting = 1'b1;
		end else if (code == KEY_CLEAR) begin
			clear_entry();
			lamp    = 1'b1;
			waiting = 1'b1;
		end else if (code == KEY_ENTER && !waiting) begin
			opened = 1'b1;
			for (int i = 0; i < CODE_LEN; i++) begin
				if (entry_buf[i] != ((i < SECRET_DIGITS) ? code_word[4*i +: 4] : 4'd0))
					opened = 1'b0;
			end
			clear_entry();
			lamp    = 1'b1;
			waiting = 1'b1;
		end else if (waiting && key_bits == '0) begin
			waiting = 1'b0;
			lamp    = 1'b0;
		end else if (code == KEY_BACK && !waiting) begin
			if (entry_count > 0) begin
				entry_count = entry_count - 4'd1;
				entry_buf[entry_count] = '0;
			end
			waiting = 1'b1;
		end else if (waiting && key_bits != '0) begin
			lamp = 1'b1;
		end
		r.row_drive      = row_out;
		r.led_on         = lamp;
		r.unlocked       = opened;
		r.digits_entered = entry_count;
		r.key_map        = key_bits;
		return r;
	endfunction

	// input side: offer the oldest pending tick, predict on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				lock_results_due.push_back(lock_tick(column_levels));
				void'(tick_queue.pop_front());
			end
			if (!(push && full)) begin
				if (tick_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					push          <= 1'b1;
					column_levels <= tick_queue[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string name, input logic [15:0] want,
			input logic [15:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
	endtask

	// result side: check each transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got = '{row_drive, led_on, unlocked, digits_entered, key_map};
				if (lock_results_due.size() == 0) begin
					errors++;
					$display("%0t: result with none pending, expected nothing actual %h",
						$time, got);
				end else begin
					want = lock_results_due.pop_front();
					if (got.row_drive !== want.row_drive)
						report_mismatch("row_drive", want.row_drive, got.row_drive);
					if (got.led_on !== want.led_on)
						report_mismatch("led_on", want.led_on, got.led_on);
					if (got.unlocked !== want.unlocked)
						report_mismatch("unlocked", want.unlocked, got.unlocked);
					if (got.digits_entered !== want.digits_entered)
						report_mismatch("digits_entered", want.digits_entered,
							got.digits_entered);
					if (got.key_map !== want.key_map)
						report_mismatch("key_map", want.key_map, got.key_map);
				end
			end
			// long hold-off so the block fills up and stalls its input
			if (hold_seen != hold_start) begin
				hold_seen = hold_start;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [SECRET_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == REG_SCAN_INTERVAL) begin
			scan_period = data[15:0];
			g_period    = int'(data[15:0]);
		end else begin
			code_word = data;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// queue ticks holding the given keys until that many row scans have passed
	task automatic gen_ticks(input logic [MAP_W-1:0] keys, input int scans);
		int         done;
		logic [3:0] cols;
		done = 0;
		while (done < scans) begin
			if (g_ticks < 65535) g_ticks++;
			if (g_ticks >= g_period) begin
				g_ticks = 0;
				cols    = ~keys[{g_row, 2'b00} +: 4];
				g_row   = g_row + 2'd1;
				done++;
			end else begin
				cols = 4'($urandom_range(0, 15));
			end
			tick_queue.push_back(cols);
			phase_items++;
		end
	endtask

	task automatic tap(input int pos);
		gen_ticks(16'b1 << pos, ($urandom_range(0, 5) == 0) ? 12 : $urandom_range(4, 6));
		gen_ticks('0, 4);
	endtask

	task automatic type_digit(input int d);
		tap(DIGIT_POS[d]);
	endtask

	function automatic int secret_digit(input logic [SECRET_W-1:0] s, input int i);
		return s[4*i +: 4] % 10;
	endfunction

	function automatic logic [SECRET_W-1:0] make_secret();
		logic [SECRET_W-1:0] s;
		int                  keep;
		for (int i = 0; i < SECRET_DIGITS; i++) s[4*i +: 4] = 4'($urandom_range(0, 9));
		// trailing zeros let a short entry match
		if ($urandom_range(0, 1) == 1) begin
			keep = $urandom_range(0, SECRET_DIGITS - 1);
			for (int i = keep; i < SECRET_DIGITS; i++) s[4*i +: 4] = '0;
		end
		return s;
	endfunction

	// one entry attempt: mostly well-formed, some wrong, cleared or noisy
	task automatic code_attempt(input logic [SECRET_W-1:0] s);
		int kind;
		int n;
		int bad;
		gen_ticks('0, 4);
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(20, 40)) begin
				case ($urandom_range(0, 3))
					0: gen_ticks(16'($urandom_range(0, 65535)), 1);
					1: gen_ticks('0, 1);
					default: gen_ticks(16'b1 << $urandom_range(0, 15), 1);
				endcase
			end
			gen_ticks((16'b1 << $urandom_range(0, 15)) | (16'b1 << $urandom_range(0, 15)), 5);
			gen_ticks('0, 4);
		end else if (kind == 7) begin
			n = $urandom_range(1, CODE_LEN);
			for (int i = 0; i < n; i++) type_digit(secret_digit(s, i));
			gen_ticks(16'b1 << POS_CLEAR, $urandom_range(4, 10));
			gen_ticks('0, 4);
			tap(POS_BACK);
			tap(POS_ENTER);
		end else begin
			n   = (kind == 5) ? $urandom_range(0, CODE_LEN) : CODE_LEN;
			bad = (kind == 6) ? $urandom_range(0, CODE_LEN - 1) : -1;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					type_digit($urandom_range(0, 9));
					tap(POS_BACK);
				end
				type_digit((i == bad) ? (secret_digit(s, i) + 1) % 10 : secret_digit(s, i));
			end
			// extra digits on a full buffer are dropped
			if (kind == 8) repeat ($urandom_range(1, 3)) type_digit($urandom_range(0, 9));
			tap(POS_ENTER);
		end
	endtask

	task automatic drain();
		while (tick_queue.size() != 0 || push || lock_results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		send_idle_pct  = SEND_IDLE[mode];
		recv_stall_pct = RECV_STALL[mode];
	endtask

	initial begin
		logic [SECRET_W-1:0] sec;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset scan rate: clear held on the first row over two scans
		set_idling(0);
		@(negedge clk);
		gen_ticks(16'b1 << POS_CLEAR, 2);
		drain();

		// reset secret code, entered at the fastest scan rate
		write_reg(REG_SCAN_INTERVAL, SECRET_W'(1));
		@(negedge clk);
		gen_ticks('0, 4);
		for (int i = 0; i < SECRET_DIGITS; i++) type_digit(secret_digit(SECRET_CODE_RST, i));
		tap(POS_ENTER);

		// single keys and function keys
		tap(POS_BACK);
		type_digit(7);
		type_digit(0);
		tap(POS_BACK);
		tap(POS_UNUSED);
		gen_ticks((16'b1 << DIGIT_POS[1]) | (16'b1 << DIGIT_POS[2]), 5);
		gen_ticks('0, 4);
		gen_ticks(16'b1 << POS_CLEAR, 10);
		gen_ticks('0, 4);
		type_digit(9);
		tap(POS_ENTER);
		drain();

		// random entry attempts under several settings and idling patterns
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_SCAN_INTERVAL, SECRET_W'(PHASE_PERIOD[m]));
			sec = (m == 2) ? '0 : (m == 3) ? '1 : make_secret();
			write_reg(REG_SECRET_CODE, sec);
			set_idling(m % 4);
			@(negedge clk);
			phase_items = 0;
			if (m == 0) hold_start++;
			while (phase_items < PHASE_ITEMS) code_attempt(sec);
			drain();
		end

		// zero scan interval: a scan on every tick
		write_reg(REG_SCAN_INTERVAL, '0);
		set_idling(0);
		@(negedge clk);
		type_digit($urandom_range(0, 9));
		drain();

		repeat (8) @(posedge clk);
		if (errors == 0 && lock_results_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/kscl_pkg.sv
hdl/kscl_fifo.sv
hdl/kscl_front.sv
hdl/kscl_back.sv
hdl/keypad_scanner_code_lock.sv
dv/keypad_scanner_code_lock_test.sv
